[hw/rtl/reentrant_rw_lock_manager_assert.svh]
// assertion macros for the lock manager
`ifndef REENTRANT_RW_LOCK_MANAGER_ASSERT_SVH
`define REENTRANT_RW_LOCK_MANAGER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define RWL_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define RWL_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[hw/rtl/rwl_pkg.sv]
// shared types and status codes of the lock manager
`default_nettype none
package rwl_pkg;
    localparam logic [2:0] OP_TRY_SHARED  = 3'd0;
    localparam logic [2:0] OP_REL_SHARED  = 3'd1;
    localparam logic [2:0] OP_TRY_EXCL    = 3'd2;
    localparam logic [2:0] OP_FINISH_UPG  = 3'd3;
    localparam logic [2:0] OP_REL_EXCL    = 3'd4;

    localparam logic [3:0] ST_OK             = 4'd0;
    localparam logic [3:0] ST_SHARED_BLOCKED = 4'd1;
    localparam logic [3:0] ST_EXCL_BLOCKED   = 4'd2;
    localparam logic [3:0] ST_OTHER_READERS  = 4'd3;
    localparam logic [3:0] ST_DEADLOCK       = 4'd4;
    localparam logic [3:0] ST_NO_RESOURCES   = 4'd5;
    localparam logic [3:0] ST_PENDING        = 4'd6;
    localparam logic [3:0] ST_MISUSE         = 4'd7;
    localparam logic [3:0] ST_NONE_PENDING   = 4'd8;

    localparam int TID_BITS   = 16;
    localparam int DEPTH_BITS = 16;
    localparam int GEN_BITS   = 16;

    // classified request passed from front to back
    typedef struct packed {
        logic [2:0]          op;
        logic [TID_BITS-1:0] tid;
        logic                bad;
    } req_t;
endpackage
`default_nettype wire

[hw/rtl/rwl_front.sv]
// request front end: classifies a request and holds it for the back end
`default_nettype none
module rwl_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [2:0]   op,
    input  wire logic [15:0]  thread_id,
    output logic              busy,
    output rwl_pkg::req_t     req,
    output logic              req_valid,
    input  wire logic         req_take,
    input  wire logic         back_idle
);
    import rwl_pkg::*;

    req_t req_reg, req_next;
    logic full_reg, full_next;

    // one-deep queue; busy until the back end has finished the word
    assign busy      = full_reg || !back_idle;
    assign req       = req_reg;
    assign req_valid = full_reg;

    always_comb
    begin
        req_next  = req_reg;
        full_next = full_reg;
        if (req_take)
        begin
            full_next = 1'b0;
        end
        if (start && !busy)
        begin
            req_next.op  = op;
            req_next.tid = thread_id;
            req_next.bad = (thread_id == '0) || (op > OP_REL_EXCL);
            full_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end
endmodule
`default_nettype wire

[hw/rtl/rwl_back.sv]
// execution back end: scans the tables, then applies the update
`default_nettype none
module rwl_back #(
    parameter int READER_SLOTS  = 16,
    parameter int UPGRADE_SLOTS = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  rwl_pkg::req_t          req,
    input  wire logic              req_valid,
    output logic                   req_take,
    output logic                   back_idle,
    output logic                   done,
    output logic [3:0]             status,
    output logic [15:0]            owner_id,
    output logic [15:0]            owner_depth,
    output logic [4:0]             reader_total
);
    import rwl_pkg::*;

    localparam int RIW = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
    localparam int UIW = (UPGRADE_SLOTS > 1) ? $clog2(UPGRADE_SLOTS) : 1;
    localparam int RCW = $clog2(READER_SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;
    req_t       cur_reg;

    logic [TID_BITS-1:0]   owner_reg;
    logic [DEPTH_BITS-1:0] nest_reg;
    logic [GEN_BITS-1:0]   gen_reg;
    logic [TID_BITS-1:0]   rid_reg [READER_SLOTS];
    logic [READER_SLOTS-1:0] rvalid_reg;
    logic [TID_BITS-1:0]   uid_reg [UPGRADE_SLOTS];
    logic [GEN_BITS-1:0]   usnap_reg [UPGRADE_SLOTS];
    logic [UPGRADE_SLOTS-1:0] uvalid_reg;
    logic [RCW-1:0]        rcount_reg;

    // scan results
    logic [READER_SLOTS-1:0]  rmatch, rother;
    logic [UPGRADE_SLOTS-1:0] umatch, uother;
    logic [READER_SLOTS-1:0]  rmatch_reg, rfree_reg;
    logic [UPGRADE_SLOTS-1:0] umatch_reg, ufree_reg;
    logic rother_reg, uother_reg;

    logic [TID_BITS-1:0] tid_w;
    assign tid_w = cur_reg.tid;

    always_comb
    begin
        for (int i = 0; i < READER_SLOTS; i++)
        begin
            rmatch[i] = rvalid_reg[i] && (rid_reg[i] == tid_w);
            rother[i] = rvalid_reg[i] && (rid_reg[i] != tid_w);
        end
        for (int j = 0; j < UPGRADE_SLOTS; j++)
        begin
            umatch[j] = uvalid_reg[j] && (uid_reg[j] == tid_w);
            uother[j] = uvalid_reg[j] && (uid_reg[j] != tid_w);
        end
    end

    // lowest-set one-hot
    function automatic logic [READER_SLOTS-1:0] low_r(input logic [READER_SLOTS-1:0] v);
        return v & (~v + 1'b1);
    endfunction
    function automatic logic [UPGRADE_SLOTS-1:0] low_u(input logic [UPGRADE_SLOTS-1:0] v);
        return v & (~v + 1'b1);
    endfunction

    logic [READER_SLOTS-1:0]  rm1, rf1;
    logic [UPGRADE_SLOTS-1:0] um1, uf1;
    logic                     usnap_ok;
    assign rm1 = low_r(rmatch_reg);
    assign rf1 = low_r(rfree_reg);
    assign um1 = low_u(umatch_reg);
    assign uf1 = low_u(ufree_reg);

    always_comb
    begin
        usnap_ok = 1'b0;
        for (int j = 0; j < UPGRADE_SLOTS; j++)
        begin
            if (um1[j] && usnap_reg[j] == gen_reg)
            begin
                usnap_ok = 1'b1;
            end
        end
    end

    logic [TID_BITS-1:0]   owner_next;
    logic [DEPTH_BITS-1:0] nest_next;
    logic [GEN_BITS-1:0]   gen_next;
    logic [READER_SLOTS-1:0]  rset, rclr;
    logic [UPGRADE_SLOTS-1:0] uset, uclr;
    logic [3:0]            st;
    logic                  own_none, own_me;

    assign own_none = (owner_reg == '0);
    assign own_me   = (owner_reg == tid_w);

    always_comb
    begin
        owner_next = owner_reg;
        nest_next  = nest_reg;
        gen_next   = gen_reg;
        rset = '0;
        rclr = '0;
        uset = '0;
        uclr = '0;
        st   = ST_MISUSE;
        if (!cur_reg.bad)
        begin
            unique case (cur_reg.op)
                OP_TRY_SHARED:
                begin
                    if (!own_none && !own_me)
                    begin
                        st = ST_SHARED_BLOCKED;
                    end
                    else if (rfree_reg != '0)
                    begin
                        rset = rf1;
                        st   = ST_OK;
                    end
                    else
                    begin
                        st = ST_NO_RESOURCES;
                    end
                end
                OP_REL_SHARED:
                begin
                    if ((!own_none && !own_me) || rcount_reg == '0)
                    begin
                        st = ST_MISUSE;
                    end
                    else
                    begin
                        rclr = rm1;
                        st   = ST_OK;
                    end
                end
                OP_TRY_EXCL:
                begin
                    if (own_me)
                    begin
                        if (nest_reg == '1)
                        begin
                            st = ST_NO_RESOURCES;
                        end
                        else
                        begin
                            nest_next = nest_reg + 1'b1;
                            st        = ST_OK;
                        end
                    end
                    else if (!own_none)
                    begin
                        st = ST_EXCL_BLOCKED;
                    end
                    else if (rmatch_reg == '0)
                    begin
                        if (rother_reg)
                        begin
                            st = ST_OTHER_READERS;
                        end
                        else
                        begin
                            owner_next = tid_w;
                            nest_next  = DEPTH_BITS'(1);
                            st         = ST_OK;
                        end
                    end
                    else if (ufree_reg != '0)
                    begin
                        uset = uf1;
                        st   = ST_PENDING;
                    end
                    else
                    begin
                        st = ST_NO_RESOURCES;
                    end
                end
                OP_FINISH_UPG:
                begin
                    if (umatch_reg == '0)
                    begin
                        st = ST_NONE_PENDING;
                    end
                    else
                    begin
                        uclr = um1;
                        if (!usnap_ok)
                        begin
                            st = ST_DEADLOCK;
                        end
                        else if (uother_reg)
                        begin
                            gen_next = gen_reg + 1'b1;
                            st       = ST_DEADLOCK;
                        end
                        else if (!own_none)
                        begin
                            st = ST_EXCL_BLOCKED;
                        end
                        else if (rother_reg)
                        begin
                            st = ST_OTHER_READERS;
                        end
                        else
                        begin
                            owner_next = tid_w;
                            nest_next  = DEPTH_BITS'(1);
                            st         = ST_OK;
                        end
                    end
                end
                OP_REL_EXCL:
                begin
                    if (own_none || !own_me)
                    begin
                        st = ST_MISUSE;
                    end
                    else
                    begin
                        st = ST_OK;
                        if (nest_reg <= DEPTH_BITS'(1))
                        begin
                            nest_next  = '0;
                            owner_next = '0;
                        end
                        else
                        begin
                            nest_next = nest_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    st = ST_MISUSE;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req_valid) state_next = S_SCAN;
            S_SCAN: state_next = S_EXEC;
            S_EXEC: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign req_take  = (state_reg == S_IDLE) && req_valid;
    assign back_idle = (state_reg == S_IDLE);

    logic exec;
    assign exec = (state_reg == S_EXEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            owner_reg  <= '0;
            nest_reg   <= '0;
            gen_reg    <= '0;
            rvalid_reg <= '0;
            uvalid_reg <= '0;
            rcount_reg <= '0;
            done       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= exec;
            if (exec)
            begin
                owner_reg  <= owner_next;
                nest_reg   <= nest_next;
                gen_reg    <= gen_next;
                rvalid_reg <= (rvalid_reg | rset) & ~rclr;
                uvalid_reg <= (uvalid_reg | uset) & ~uclr;
                rcount_reg <= rcount_reg + RCW'(rset != '0) - RCW'(rclr != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cur_reg <= req;
        end
        if (state_reg == S_SCAN)
        begin
            rmatch_reg <= rmatch;
            rfree_reg  <= ~rvalid_reg;
            rother_reg <= |rother;
            umatch_reg <= umatch;
            ufree_reg  <= ~uvalid_reg;
            uother_reg <= |uother;
        end
        if (exec)
        begin
            for (int i = 0; i < READER_SLOTS; i++)
            begin
                if (rset[i]) rid_reg[i] <= tid_w;
            end
            for (int j = 0; j < UPGRADE_SLOTS; j++)
            begin
                if (uset[j])
                begin
                    uid_reg[j]   <= tid_w;
                    usnap_reg[j] <= gen_reg;
                end
            end
            status       <= st;
            owner_id     <= 16'(owner_next);
            owner_depth  <= nest_next;
            reader_total <= 5'(rcount_reg + RCW'(rset != '0) - RCW'(rclr != '0));
        end
    end
endmodule
`default_nettype wire

[hw/rtl/reentrant_rw_lock_manager.sv]
// top level of the re-entrant reader-writer lock manager
`default_nettype none
`include "reentrant_rw_lock_manager_assert.svh"
// A request word is taken when start is high and busy is low. Each word passes
// from acceptance to its result through the front queue, a compare of the thread
// against every reader and upgrade slot, the update and the result register.
// done pulses for exactly one cycle with status and the lock view; the receiver
// cannot stall it, and busy stays high until the word is finished, so the next
// word can follow immediately after.
module reentrant_rw_lock_manager #(
    parameter int READER_SLOTS  = 16,
    parameter int UPGRADE_SLOTS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  op,
    input  wire logic [15:0] thread_id,
    output logic             done,
    output logic [3:0]       status,
    output logic [15:0]      owner_id,
    output logic [15:0]      owner_depth,
    output logic [4:0]       reader_total
);
    import rwl_pkg::*;

    req_t req;
    logic req_valid, req_take, back_idle;

    rwl_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .op(op), .thread_id(thread_id),
        .busy(busy), .req(req), .req_valid(req_valid), .req_take(req_take),
        .back_idle(back_idle)
    );

    rwl_back #(
        .READER_SLOTS(READER_SLOTS), .UPGRADE_SLOTS(UPGRADE_SLOTS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_take(req_take), .back_idle(back_idle), .done(done), .status(status),
        .owner_id(owner_id), .owner_depth(owner_depth), .reader_total(reader_total)
    );

    `RWL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy, "no busy after accept")
    `RWL_ASSERT_IMP(a_status_range, clk, rst_n, done, status <= ST_NONE_PENDING, "bad status")
    `RWL_ASSERT_IMP(a_depth_owner, clk, rst_n, done && owner_id == '0, owner_depth == '0, "depth without owner")
    `RWL_ASSERT_NEXT(a_single_done, clk, rst_n, done, !done, "double result")
endmodule
`default_nettype wire
